>>> hdl/pdu_hdr_pkg.sv
package pdu_hdr_pkg;

  localparam int WORD_W   = 32;
  localparam int VB_W     = 3;
  localparam int FIELD_W  = 30;
  localparam int HALF_W   = 16;
  localparam int ALGO_W   = 8;
  localparam int DLV_W    = 2;
  localparam int REASON_W = 27;
  localparam int FLAGS_W  = 4;
  localparam int PHASE_W  = 3;

  localparam int MAX_PAYLOAD_BYTES_DEF = 16384;

  localparam logic [VB_W-1:0] FULL_WORD_BYTES = 3'd4;

  // header type codes in bits 31:30
  localparam logic [1:0] HT_ACK  = 2'b00;
  localparam logic [1:0] HT_INIT = 2'b01;
  localparam logic [1:0] HT_DATA = 2'b10;
  localparam logic [1:0] HT_NACK = 2'b11;

  // header_flags bit positions
  localparam int FLAG_DATA = 0;
  localparam int FLAG_INIT = 1;
  localparam int FLAG_ACK  = 2;
  localparam int FLAG_NACK = 3;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [VB_W-1:0]   valid_bytes;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic [FLAGS_W-1:0]  header_flags;
    logic [FIELD_W-1:0]  offset;
    logic [FIELD_W-1:0]  total_size;
    logic [HALF_W-1:0]   message_id;
    logic [HALF_W-1:0]   auth_code;
    logic [ALGO_W-1:0]   algorithms;
    logic [DLV_W-1:0]    delivery_flags;
    logic [REASON_W-1:0] nack_reason;
    logic                pdu_ok;
  } hdr_res_t;

  // handshake between the input stage and the parser
  typedef struct packed {
    logic valid;
    logic ready;
  } stage_ctl_t;

endpackage

>>> hdl/pdu_hdr_if.sv
interface pdu_hdr_in_if import pdu_hdr_pkg::*;;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] word;
  logic [VB_W-1:0]   valid_bytes;
  logic              last;

  modport source (output valid, word, valid_bytes, last, input ready);
  modport sink   (input valid, word, valid_bytes, last, output ready);
endinterface

interface pdu_hdr_out_if import pdu_hdr_pkg::*; #(
  parameter int PB_W = $clog2(MAX_PAYLOAD_BYTES_DEF + 1)
);
  logic                valid;
  logic                ready;
  logic [FLAGS_W-1:0]  header_flags;
  logic [FIELD_W-1:0]  offset;
  logic [FIELD_W-1:0]  total_size;
  logic [HALF_W-1:0]   message_id;
  logic [HALF_W-1:0]   auth_code;
  logic [ALGO_W-1:0]   algorithms;
  logic [DLV_W-1:0]    delivery_flags;
  logic [REASON_W-1:0] nack_reason;
  logic                pdu_ok;
  logic [PB_W-1:0]     payload_bytes;

  modport source (output valid, header_flags, offset, total_size, message_id, auth_code,
                  algorithms, delivery_flags, nack_reason, pdu_ok, payload_bytes,
                  input ready);
  modport sink   (input valid, header_flags, offset, total_size, message_id, auth_code,
                  algorithms, delivery_flags, nack_reason, pdu_ok, payload_bytes,
                  output ready);
endinterface

>>> hdl/pdu_hdr_in_stage.sv
module pdu_hdr_in_stage import pdu_hdr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_item,
  output stage_ctl_t ctl_out,
  input  logic       pop,
  output in_item_t   item
);

  logic     valid_r, valid_nxt;
  in_item_t item_r;

  assign in_ready  = !valid_r || pop;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

  assign ctl_out.valid = valid_r;
  assign ctl_out.ready = in_ready;
  assign item          = item_r;

endmodule

>>> hdl/pdu_hdr_parse.sv
module pdu_hdr_parse import pdu_hdr_pkg::*; #(
  parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF,
  parameter int PB_W              = $clog2(MAX_PAYLOAD_BYTES + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            take,
  input  in_item_t        item,
  output hdr_res_t        res,
  output logic [PB_W-1:0] res_bytes
);

  localparam logic [PHASE_W-1:0] PH_HDR   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_ACK2  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_DATA2 = 3'd2;
  localparam logic [PHASE_W-1:0] PH_INIT2 = 3'd3;
  localparam logic [PHASE_W-1:0] PH_INIT3 = 3'd4;
  localparam logic [PHASE_W-1:0] PH_PAY   = 3'd5;
  localparam logic [PHASE_W-1:0] PH_STOP  = 3'd6;

  localparam logic [PB_W:0] MAX_C = (PB_W + 1)'(MAX_PAYLOAD_BYTES);

  logic [PHASE_W-1:0]  phase_r, phase_nxt, phase_w;
  logic [FLAGS_W-1:0]  flags_r, flags_nxt, flags_w;
  logic [FIELD_W-1:0]  offset_r, offset_nxt, offset_w;
  logic [FIELD_W-1:0]  size_r, size_nxt, size_w;
  logic [WORD_W-1:0]   id_r, id_nxt, id_w;
  logic [9:0]          algo_r, algo_nxt, algo_w;
  logic [REASON_W-1:0] reason_r, reason_nxt, reason_w;
  logic                ok_r, ok_nxt, ok_w, ok_fin;
  logic [PB_W-1:0]     count_r, count_nxt, count_w;
  logic [VB_W-1:0]     add;
  logic [PB_W:0]       sum;
  logic [WORD_W-1:0]   w;

  assign w   = item.word;
  assign add = (item.valid_bytes > FULL_WORD_BYTES) ? FULL_WORD_BYTES : item.valid_bytes;
  assign sum = {1'b0, count_r} + (PB_W + 1)'(add);

  // state after this word
  always_comb begin
    phase_w  = phase_r;
    flags_w  = flags_r;
    offset_w = offset_r;
    size_w   = size_r;
    id_w     = id_r;
    algo_w   = algo_r;
    reason_w = reason_r;
    ok_w     = ok_r;
    count_w  = count_r;
    if (phase_r == PH_PAY) begin
      count_w = (sum > MAX_C) ? MAX_C[PB_W-1:0] : sum[PB_W-1:0];
    end else if (phase_r != PH_STOP) begin
      if (item.valid_bytes != FULL_WORD_BYTES) begin
        ok_w    = 1'b0;
        phase_w = PH_STOP;
      end else begin
        case (phase_r)
          PH_HDR: begin
            case (w[31:30])
              HT_ACK: begin
                flags_w[FLAG_ACK] = 1'b1;
                offset_w          = w[FIELD_W-1:0];
                phase_w           = PH_ACK2;
              end
              HT_INIT: begin
                flags_w[FLAG_INIT] = 1'b1;
                size_w             = w[FIELD_W-1:0];
                phase_w            = PH_INIT2;
              end
              HT_DATA: begin
                flags_w[FLAG_DATA] = 1'b1;
                offset_w           = w[FIELD_W-1:0];
                phase_w            = PH_DATA2;
              end
              default: begin
                flags_w[FLAG_NACK] = 1'b1;
                // nonzero subtype marks the pdu bad but parsing goes on
                if (w[29:27] == 3'b000) begin
                  reason_w = w[REASON_W-1:0];
                end else begin
                  ok_w = 1'b0;
                end
                phase_w = PH_HDR;
              end
            endcase
          end
          PH_ACK2: begin
            id_w    = w;
            phase_w = PH_HDR;
          end
          PH_DATA2: begin
            id_w    = w;
            phase_w = PH_PAY;
          end
          PH_INIT2: begin
            id_w    = w;
            phase_w = PH_INIT3;
          end
          default: begin
            algo_w  = w[9:0];
            phase_w = PH_PAY;
          end
        endcase
      end
    end
  end

  // end-of-pdu checks: stuck in headers or empty payload
  always_comb begin
    ok_fin = ok_w;
    if (phase_w == PH_PAY) begin
      if (count_w == '0) begin
        ok_fin = 1'b0;
      end
    end else if (phase_w != PH_STOP) begin
      ok_fin = 1'b0;
    end
  end

  assign res.header_flags   = flags_w;
  assign res.offset         = offset_w;
  assign res.total_size     = size_w;
  assign res.message_id     = id_w[31:16];
  assign res.auth_code      = id_w[15:0];
  assign res.algorithms     = algo_w[7:0];
  assign res.delivery_flags = algo_w[9:8];
  assign res.nack_reason    = reason_w;
  assign res.pdu_ok         = ok_fin;
  assign res_bytes          = (phase_w == PH_PAY) ? count_w : '0;

  always_comb begin
    phase_nxt  = phase_w;
    flags_nxt  = flags_w;
    offset_nxt = offset_w;
    size_nxt   = size_w;
    id_nxt     = id_w;
    algo_nxt   = algo_w;
    reason_nxt = reason_w;
    ok_nxt     = ok_w;
    count_nxt  = count_w;
    if (item.last) begin
      phase_nxt  = PH_HDR;
      flags_nxt  = '0;
      offset_nxt = '0;
      size_nxt   = '0;
      id_nxt     = '0;
      algo_nxt   = '0;
      reason_nxt = '0;
      ok_nxt     = 1'b1;
      count_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR;
      flags_r  <= '0;
      offset_r <= '0;
      size_r   <= '0;
      id_r     <= '0;
      algo_r   <= '0;
      reason_r <= '0;
      ok_r     <= 1'b1;
      count_r  <= '0;
    end else if (take) begin
      phase_r  <= phase_nxt;
      flags_r  <= flags_nxt;
      offset_r <= offset_nxt;
      size_r   <= size_nxt;
      id_r     <= id_nxt;
      algo_r   <= algo_nxt;
      reason_r <= reason_nxt;
      ok_r     <= ok_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> hdl/pdu_hdr_out_stage.sv
module pdu_hdr_out_stage import pdu_hdr_pkg::*; #(
  parameter int PB_W = $clog2(MAX_PAYLOAD_BYTES_DEF + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  hdr_res_t        res,
  input  logic [PB_W-1:0] res_bytes,
  output logic            slot_free,
  output logic            out_valid,
  input  logic            out_ready,
  output hdr_res_t        out_res,
  output logic [PB_W-1:0] out_bytes
);

  logic            valid_r, valid_nxt;
  hdr_res_t        res_r;
  logic [PB_W-1:0] bytes_r;

  assign slot_free = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r   <= res;
      bytes_r <= res_bytes;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;
  assign out_bytes = bytes_r;

endmodule

>>> hdl/pdu_header_parser.sv
// a last word on in_ch is registered in the input register at its accepting edge, and its
// summary is registered in the result register when that word is taken from there
// throughput: one word per cycle; a last word waits in the input register while a
// previous summary sits untaken in the result register
// reset: synchronous active-low rst_n empties both registers and returns the parser
// to expecting a header with all pdu fields cleared
module pdu_header_parser import pdu_hdr_pkg::*; #(
  parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF,
  parameter int PB_W              = $clog2(MAX_PAYLOAD_BYTES + 1)
) (
  input logic                 clk,
  input logic                 rst_n,
  pdu_hdr_in_if.sink          in_ch,
  pdu_hdr_out_if.source       out_ch
);

  in_item_t        in_item, item;
  stage_ctl_t      in_ctl;
  hdr_res_t        res, out_res;
  logic [PB_W-1:0] res_bytes, out_bytes;
  logic            slot_free, take, load;

  assign in_item.word        = in_ch.word;
  assign in_item.valid_bytes = in_ch.valid_bytes;
  assign in_item.last        = in_ch.last;

  // a last word needs room for its summary
  assign take = in_ctl.valid && (!item.last || slot_free);
  assign load = take && item.last;

  pdu_hdr_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_item  (in_item),
    .ctl_out  (in_ctl),
    .pop      (take),
    .item     (item)
  );

  pdu_hdr_parse #(
    .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES),
    .PB_W              (PB_W)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .item      (item),
    .res       (res),
    .res_bytes (res_bytes)
  );

  pdu_hdr_out_stage #(
    .PB_W (PB_W)
  ) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .res       (res),
    .res_bytes (res_bytes),
    .slot_free (slot_free),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res),
    .out_bytes (out_bytes)
  );

  assign out_ch.header_flags   = out_res.header_flags;
  assign out_ch.offset         = out_res.offset;
  assign out_ch.total_size     = out_res.total_size;
  assign out_ch.message_id     = out_res.message_id;
  assign out_ch.auth_code      = out_res.auth_code;
  assign out_ch.algorithms     = out_res.algorithms;
  assign out_ch.delivery_flags = out_res.delivery_flags;
  assign out_ch.nack_reason    = out_res.nack_reason;
  assign out_ch.pdu_ok         = out_res.pdu_ok;
  assign out_ch.payload_bytes  = out_bytes;

endmodule

>>> dv/pdu_summary_checker.sv
`timescale 1ns / 1ps

module pdu_summary_checker import pdu_hdr_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  pdu_hdr_in_if  in_mon,
  pdu_hdr_out_if out_mon,
  output int     fail_count,
  output int     outstanding,
  output int     summaries_seen
);

  localparam int PB_W = $clog2(MAX_PAYLOAD_BYTES_DEF + 1);

  typedef enum logic [PHASE_W-1:0] {
    PH_HDR,
    PH_ACK_ID,
    PH_DATA_ID,
    PH_INIT_ID,
    PH_INIT_MODE,
    PH_PAYLOAD,
    PH_STOP
  } parse_phase_e;

  typedef struct packed {
    hdr_res_t        hdr;
    logic [PB_W-1:0] payload_bytes;
  } pdu_summary_t;

  parse_phase_e        ph;
  logic [FLAGS_W-1:0]  seen;
  logic [FIELD_W-1:0]  offs;
  logic [FIELD_W-1:0]  size_val;
  logic [WORD_W-1:0]   id_val;
  logic [9:0]          algo_mode;
  logic [REASON_W-1:0] reason;
  logic                ok;
  int                  nbytes;

  pdu_summary_t summary_q[$];
  int errs = 0;
  int nchecked = 0;

  task automatic clear_pdu_state();
    ph        = PH_HDR;
    seen      = '0;
    offs      = '0;
    size_val  = '0;
    id_val    = '0;
    algo_mode = '0;
    reason    = '0;
    ok        = 1'b1;
    nbytes    = 0;
  endtask

  task automatic take_header(logic [WORD_W-1:0] w);
    case (w[31:30])
      HT_ACK: begin
        seen[FLAG_ACK] = 1'b1;
        offs = w[FIELD_W-1:0];
        ph = PH_ACK_ID;
      end
      HT_INIT: begin
        seen[FLAG_INIT] = 1'b1;
        size_val = w[FIELD_W-1:0];
        ph = PH_INIT_ID;
      end
      HT_DATA: begin
        seen[FLAG_DATA] = 1'b1;
        offs = w[FIELD_W-1:0];
        ph = PH_DATA_ID;
      end
      default: begin
        seen[FLAG_NACK] = 1'b1;
        // nonzero subtype spoils the pdu but the chain goes on
        if (w[29:27] == 3'b000) reason = w[REASON_W-1:0];
        else ok = 1'b0;
        ph = PH_HDR;
      end
    endcase
  endtask

  task automatic parse_word(logic [WORD_W-1:0] w, logic [VB_W-1:0] vb, logic last);
    pdu_summary_t s;
    int add;
    if (ph == PH_PAYLOAD) begin
      add = (vb > FULL_WORD_BYTES) ? int'(FULL_WORD_BYTES) : int'(vb);
      nbytes = (nbytes + add > MAX_PAYLOAD_BYTES_DEF) ? MAX_PAYLOAD_BYTES_DEF : nbytes + add;
    end else if (ph != PH_STOP) begin
      if (vb != FULL_WORD_BYTES) begin
        ok = 1'b0;
        ph = PH_STOP;
      end else begin
        case (ph)
          PH_HDR:     take_header(w);
          PH_ACK_ID: begin
            id_val = w;
            ph = PH_HDR;
          end
          PH_DATA_ID: begin
            id_val = w;
            ph = PH_PAYLOAD;
          end
          PH_INIT_ID: begin
            id_val = w;
            ph = PH_INIT_MODE;
          end
          default: begin
            algo_mode = w[9:0];
            ph = PH_PAYLOAD;
          end
        endcase
      end
    end
    if (last) begin
      // ending mid-header or with no payload bytes is a bad pdu
      if (ph == PH_PAYLOAD) begin
        if (nbytes == 0) ok = 1'b0;
      end else if (ph != PH_STOP) begin
        ok = 1'b0;
      end
      s.hdr.header_flags   = seen;
      s.hdr.offset         = offs;
      s.hdr.total_size     = size_val;
      s.hdr.message_id     = id_val[31:16];
      s.hdr.auth_code      = id_val[15:0];
      s.hdr.algorithms     = algo_mode[7:0];
      s.hdr.delivery_flags = algo_mode[9:8];
      s.hdr.nack_reason    = reason;
      s.hdr.pdu_ok         = ok;
      s.payload_bytes      = (ph == PH_PAYLOAD) ? PB_W'(nbytes) : '0;
      summary_q.push_back(s);
      clear_pdu_state();
    end
  endtask

  task automatic check_field(string name, logic [31:0] expv, logic [31:0] actv);
    if (expv !== actv) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, expv, actv);
      errs++;
    end
  endtask

  task automatic compare_summary();
    pdu_summary_t s;
    s = summary_q.pop_front();
    nchecked++;
    check_field("header_flags", 32'(s.hdr.header_flags), 32'(out_mon.header_flags));
    check_field("offset", 32'(s.hdr.offset), 32'(out_mon.offset));
    check_field("total_size", 32'(s.hdr.total_size), 32'(out_mon.total_size));
    check_field("message_id", 32'(s.hdr.message_id), 32'(out_mon.message_id));
    check_field("auth_code", 32'(s.hdr.auth_code), 32'(out_mon.auth_code));
    check_field("algorithms", 32'(s.hdr.algorithms), 32'(out_mon.algorithms));
    check_field("delivery_flags", 32'(s.hdr.delivery_flags), 32'(out_mon.delivery_flags));
    check_field("nack_reason", 32'(s.hdr.nack_reason), 32'(out_mon.nack_reason));
    check_field("pdu_ok", 32'(s.hdr.pdu_ok), 32'(out_mon.pdu_ok));
    check_field("payload_bytes", 32'(s.payload_bytes), 32'(out_mon.payload_bytes));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_pdu_state();
      summary_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        parse_word(in_mon.word, in_mon.valid_bytes, in_mon.last);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (summary_q.size() == 0) begin
          $error("summary item with no pdu end waiting for it");
          errs++;
        end else begin
          compare_summary();
        end
      end
    end
    outstanding    <= summary_q.size();
    fail_count     <= errs;
    summaries_seen <= nchecked;
  end

endmodule

>>> dv/pdu_header_parser_tb.sv
`timescale 1ns / 1ps

module pdu_header_parser_tb;
  import pdu_hdr_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RAND_WORDS  = 1400;
  localparam int LONG_WORDS  = 300;

  logic clk;
  logic rst_n;
  logic stall_en = 1'b1;

  int fail_count;
  int pending;
  int summaries_seen;
  int cycle_cnt = 0;
  int words_sent = 0;
  int pdus_sent = 0;
  int rand_words = 0;
  int rdy_hold = 0;
  bit paused_once = 0;
  bit long_done = 0;

  in_item_t pdu_words[$];

  pdu_hdr_in_if  in_ch();
  pdu_hdr_out_if out_ch();

  pdu_header_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pdu_summary_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .fail_count     (fail_count),
    .outstanding    (pending),
    .summaries_seen (summaries_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d summaries still pending", cycle_cnt, pending);
      $display("[pdu_header_parser] ERROR");
      $finish;
    end
  end

  // result side back-pressure: bursts of ready, mostly short stalls, a few long ones
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rdy_hold > 0) begin
        rdy_hold--;
      end else if (!stall_en) begin
        out_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 99) < 70) begin
        out_ch.ready <= 1'b1;
        rdy_hold = $urandom_range(0, 7);
      end else begin
        out_ch.ready <= 1'b0;
        rdy_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (!stall_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // random value of w bits, biased toward all zeros and all ones
  function automatic logic [31:0] rnd_bits(int w);
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = '1;
      default: v = $urandom;
    endcase
    return 32'(v & 32'((64'd1 << w) - 1));
  endfunction

  task automatic push_word(logic [WORD_W-1:0] w, logic [VB_W-1:0] vb, logic last);
    in_item_t it;
    it.word        = w;
    it.valid_bytes = vb;
    it.last        = last;
    pdu_words.push_back(it);
  endtask

  task automatic send_item(in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.word        <= it.word;
    in_ch.valid_bytes <= it.valid_bytes;
    in_ch.last        <= it.last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_pdu();
    foreach (pdu_words[i]) send_item(pdu_words[i]);
    words_sent += pdu_words.size();
    pdus_sent++;
    pdu_words.delete();
  endtask

  // hold the sender until every summary has come out
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  task automatic directed_pdus();
    // ack chain into data, field extremes, one-byte last payload word
    push_word({HT_ACK, 30'h3FFF_FFFF}, FULL_WORD_BYTES, 1'b0);
    push_word(32'hFFFF_FFFF, FULL_WORD_BYTES, 1'b0);
    push_word({HT_DATA, 30'h0}, FULL_WORD_BYTES, 1'b0);
    push_word(32'h0, FULL_WORD_BYTES, 1'b0);
    push_word(32'hFFFF_FFFF, 3'd1, 1'b1);
    send_pdu();
    // initial data with all-ones size and mode word
    push_word({HT_INIT, 30'h3FFF_FFFF}, FULL_WORD_BYTES, 1'b0);
    push_word(32'hA5C3_5A3C, FULL_WORD_BYTES, 1'b0);
    push_word(32'hFFFF_FFFF, FULL_WORD_BYTES, 1'b0);
    push_word(32'h1234_5678, FULL_WORD_BYTES, 1'b1);
    send_pdu();
    // clean nack, then empty mid payload word and an oversized byte count
    push_word({HT_NACK, 3'b000, 27'h7FF_FFFF}, FULL_WORD_BYTES, 1'b0);
    push_word({HT_DATA, 30'h3FFF_FFFF}, FULL_WORD_BYTES, 1'b0);
    push_word(32'h5A5A_A5A5, FULL_WORD_BYTES, 1'b0);
    push_word(32'h0, 3'd0, 1'b0);
    push_word(32'hFFFF_FFFF, 3'd7, 1'b1);
    send_pdu();
    // nack with nonzero subtype, init with zero fields
    push_word({HT_NACK, 3'b111, 27'h0}, FULL_WORD_BYTES, 1'b0);
    push_word({HT_INIT, 30'h0}, FULL_WORD_BYTES, 1'b0);
    push_word(32'h0, FULL_WORD_BYTES, 1'b0);
    push_word(32'h0, FULL_WORD_BYTES, 1'b0);
    push_word(32'h0, 3'd5, 1'b1);
    send_pdu();
    // short word where a header is expected, rest ignored
    push_word({HT_ACK, 30'h1}, 3'd3, 1'b0);
    push_word(32'hFFFF_FFFF, 3'd6, 1'b1);
    send_pdu();
    // pdu ends right after an ack header
    push_word({HT_ACK, 30'h2AAA_AAAA}, FULL_WORD_BYTES, 1'b0);
    push_word(32'h8001_7FFE, FULL_WORD_BYTES, 1'b1);
    send_pdu();
    // lone nack header
    push_word({HT_NACK, 3'b000, 27'h155_5555}, FULL_WORD_BYTES, 1'b1);
    send_pdu();
    // data header with no payload at all
    push_word({HT_DATA, 30'h1555_5555}, FULL_WORD_BYTES, 1'b0);
    push_word(32'hDEAD_BEEF, FULL_WORD_BYTES, 1'b1);
    send_pdu();
    // payload present but zero bytes
    push_word({HT_DATA, 30'h7}, FULL_WORD_BYTES, 1'b0);
    push_word(32'h0000_FFFF, FULL_WORD_BYTES, 1'b0);
    push_word(32'hFFFF_0000, 3'd0, 1'b1);
    send_pdu();
  endtask

  task automatic build_random_pdu();
    int kind;
    int npre;
    int npay;
    int hdr_len;
    int cut;
    int v;
    logic [2:0] sub;
    logic [VB_W-1:0] vb;
    kind = $urandom_range(0, 99);
    if (kind >= 90) begin
      // noise: arbitrary words, sizes and ends
      npay = $urandom_range(1, 6);
      for (int i = 0; i < npay; i++) begin
        push_word($urandom, VB_W'($urandom_range(0, 7)),
                  (i == npay - 1) || ($urandom_range(0, 3) == 0));
      end
      return;
    end
    npre = $urandom_range(0, 3);
    for (int i = 0; i < npre; i++) begin
      if ($urandom_range(0, 1) == 1) begin
        push_word({HT_ACK, 30'(rnd_bits(30))}, FULL_WORD_BYTES, 1'b0);
        push_word(rnd_bits(32), FULL_WORD_BYTES, 1'b0);
      end else begin
        sub = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(1, 7)) : 3'b000;
        push_word({HT_NACK, sub, 27'(rnd_bits(27))}, FULL_WORD_BYTES, 1'b0);
      end
    end
    if ($urandom_range(0, 1) == 1) begin
      push_word({HT_DATA, 30'(rnd_bits(30))}, FULL_WORD_BYTES, 1'b0);
      push_word(rnd_bits(32), FULL_WORD_BYTES, 1'b0);
    end else begin
      push_word({HT_INIT, 30'(rnd_bits(30))}, FULL_WORD_BYTES, 1'b0);
      push_word(rnd_bits(32), FULL_WORD_BYTES, 1'b0);
      push_word(rnd_bits(32), FULL_WORD_BYTES, 1'b0);
    end
    hdr_len = pdu_words.size();
    npay = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
    for (int i = 0; i < npay; i++) begin
      vb = (i == npay - 1) ? VB_W'($urandom_range(1, 4)) : FULL_WORD_BYTES;
      if ($urandom_range(0, 9) == 0) vb = VB_W'($urandom_range(0, 7));
      push_word($urandom, vb, i == npay - 1);
    end
    if (kind >= 75) begin
      if ($urandom_range(0, 1) == 1) begin
        // cut the pdu somewhere inside its headers
        cut = $urandom_range(1, hdr_len);
        while (pdu_words.size() > cut) void'(pdu_words.pop_back());
        pdu_words[cut-1].last = 1'b1;
      end else begin
        // short word in a header position
        v = $urandom_range(0, 6);
        if (v >= 4) v++;
        pdu_words[$urandom_range(0, hdr_len - 1)].valid_bytes = VB_W'(v);
      end
    end
  endtask

  task automatic long_pdu();
    push_word({HT_DATA, 30'(rnd_bits(30))}, FULL_WORD_BYTES, 1'b0);
    push_word(rnd_bits(32), FULL_WORD_BYTES, 1'b0);
    for (int i = 0; i < LONG_WORDS; i++) push_word($urandom, FULL_WORD_BYTES, i == LONG_WORDS - 1);
    send_pdu();
  endtask

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.word        = '0;
    in_ch.valid_bytes = '0;
    in_ch.last        = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    directed_pdus();
    drain();

    while (rand_words < RAND_WORDS) begin
      // every fourth stretch runs with no idling on either side
      stall_en = ((rand_words / 300) % 4) != 3;
      build_random_pdu();
      rand_words += pdu_words.size();
      send_pdu();
      if (!paused_once && rand_words >= RAND_WORDS / 2) begin
        drain();
        paused_once = 1;
      end
      if (!long_done && rand_words >= (RAND_WORDS * 2) / 3) begin
        stall_en = 1'b0;
        long_pdu();
        long_done = 1;
      end
    end

    stall_en = 1'b1;
    drain();
    repeat (10) @(posedge clk);

    $display("covered %0d pdus in %0d words: ack/nack chains, data and initial data,",
             pdus_sent, words_sent);
    $display("broken and noisy pdus, a long payload; %0d summaries compared",
             summaries_seen);
    if (fail_count == 0) begin
      $display("[pdu_header_parser] OK");
    end else begin
      $display("[pdu_header_parser] ERROR");
    end
    $finish;
  end

endmodule
